### rtl/bhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Board handling sequencer package
// Shared types, codes and constants of the board handling sequencer.
// ----------------------------------------------------------------------------
package bhs_pkg;

  // Field widths.
  localparam int unsigned OpW      = 3;
  localparam int unsigned SensorW  = 2;
  localparam int unsigned ActW     = 3;
  localparam int unsigned MsW      = 16;
  localparam int unsigned StateW   = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Default drive time of a plain actuator pulse, in milliseconds.
  localparam logic [MsW-1:0] PulseMsDefault = 16'd100;

  // Register reset values.
  localparam logic           EntryFromLeftReset = 1'b1;
  localparam logic [MsW-1:0] EntryRunMsReset    = 16'd1000;
  localparam logic [MsW-1:0] ExitRunMsReset     = 16'd1000;

  // Pulses a single command can cause, and the counter widths that follow.
  localparam int unsigned PlanPulses = 4;
  localparam int unsigned PulseIdxW  = $clog2(PlanPulses);
  localparam int unsigned PulseCntW  = $clog2(PlanPulses + 1);

  // Depth of the queue between the front and the back end.
  localparam int unsigned QueueDepth = 2;

  // Commands.
  typedef enum logic [OpW-1:0] {
    OP_CLEAR    = 3'd0,
    OP_ACCEPT   = 3'd1,
    OP_CLAMP    = 3'd2,
    OP_RAISE    = 3'd3,
    OP_LOWER    = 3'd4,
    OP_RELEASE  = 3'd5,
    OP_SEND_OUT = 3'd6
  } op_e;

  // Board states.
  typedef enum logic [StateW-1:0] {
    ST_NONE    = 3'd0,
    ST_ACCEPT  = 3'd1,
    ST_CLAMP   = 3'd2,
    ST_UP      = 3'd3,
    ST_DOWN    = 3'd4,
    ST_RELEASE = 3'd5,
    ST_OUT     = 3'd6
  } board_state_e;

  // Actuator codes on the result channel.
  typedef enum logic [ActW-1:0] {
    ACT_NONE      = 3'd0,
    ACT_GATE_UP   = 3'd1,
    ACT_GATE_DOWN = 3'd2,
    ACT_CONVEYOR  = 3'd3,
    ACT_CLAMP     = 3'd4,
    ACT_UNCLAMP   = 3'd5,
    ACT_LIFT_UP   = 3'd6,
    ACT_LIFT_DOWN = 3'd7
  } actuator_e;

  // Pulse kinds of a plan; the two conveyor runs differ in their drive time.
  typedef enum logic [2:0] {
    P_GATE_UP   = 3'd0,
    P_GATE_DOWN = 3'd1,
    P_ENTRY_RUN = 3'd2,
    P_EXIT_RUN  = 3'd3,
    P_CLAMP     = 3'd4,
    P_UNCLAMP   = 3'd5,
    P_LIFT_UP   = 3'd6,
    P_LIFT_DOWN = 3'd7
  } pulse_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_ENTRY_FROM_LEFT = 2'd0,
    REG_ENTRY_RUN_MS    = 2'd1,
    REG_EXIT_RUN_MS     = 2'd2
  } cfg_reg_e;

  // Command word.
  typedef struct packed {
    logic [OpW-1:0]     operation;
    logic [SensorW-1:0] entry_sensors_n;
  } cmd_t;

  // Result word.
  typedef struct packed {
    logic [ActW-1:0]   actuator;
    logic [MsW-1:0]    pulse_ms;
    logic              success;
    logic [StateW-1:0] board_state;
    logic              last;
  } res_t;

  // Configuration write word.
  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

  // Classified command: the pulses to issue and the resulting status.
  typedef struct packed {
    pulse_e [PlanPulses-1:0] pulse;
    logic [PulseCntW-1:0]    pulse_cnt;
    logic                    success;
    board_state_e            state;
  } plan_t;

endpackage

### rtl/bhs_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Board handling sequencer stream channel
// Valid/ready channel carrying one word of the given payload type.
// ----------------------------------------------------------------------------
interface bhs_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

### rtl/bhs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Board handling sequencer front end
// Accepts commands, resolves the prerequisite cascade against the tracked
// board state and pushes the resulting plan into the queue.
// ----------------------------------------------------------------------------
module bhs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bhs_stream_if.sink           cmd_i,
  input  logic                 entry_from_left_i,
  output logic                 push_valid_o,
  output bhs_pkg::plan_t       push_plan_o,
  input  logic                 push_ready_i
);

  bhs_pkg::board_state_e state_q, state_d;
  bhs_pkg::plan_t        plan;
  logic                  present;
  logic                  take;

  // Append one pulse to a plan.
  function automatic bhs_pkg::plan_t add_pulse(bhs_pkg::plan_t p, bhs_pkg::pulse_e k);
    p.pulse[p.pulse_cnt[bhs_pkg::PulseIdxW-1:0]] = k;
    p.pulse_cnt = p.pulse_cnt + bhs_pkg::PulseCntW'(1);
    return p;
  endfunction

  function automatic bhs_pkg::plan_t run_accept(bhs_pkg::plan_t p, logic present_i);
    if (p.state == bhs_pkg::ST_ACCEPT) begin
      p.success = 1'b1;
    end else if (p.state != bhs_pkg::ST_NONE && p.state != bhs_pkg::ST_OUT) begin
      p.success = 1'b0;
    end else if (!present_i) begin
      p.success = 1'b0;
    end else begin
      p = add_pulse(p, bhs_pkg::P_GATE_UP);
      p = add_pulse(p, bhs_pkg::P_ENTRY_RUN);
      p.state   = bhs_pkg::ST_ACCEPT;
      p.success = 1'b1;
    end
    return p;
  endfunction

  function automatic bhs_pkg::plan_t run_clamp(bhs_pkg::plan_t p, logic present_i);
    if (p.state == bhs_pkg::ST_CLAMP) begin
      p.success = 1'b1;
    end else begin
      if (p.state != bhs_pkg::ST_ACCEPT && p.state != bhs_pkg::ST_RELEASE) begin
        p = run_accept(p, present_i);
      end
      if (p.state != bhs_pkg::ST_ACCEPT && p.state != bhs_pkg::ST_RELEASE) begin
        p.success = 1'b0;
      end else begin
        p = add_pulse(p, bhs_pkg::P_CLAMP);
        p.state   = bhs_pkg::ST_CLAMP;
        p.success = 1'b1;
      end
    end
    return p;
  endfunction

  function automatic bhs_pkg::plan_t run_raise(bhs_pkg::plan_t p, logic present_i);
    if (p.state == bhs_pkg::ST_UP) begin
      p.success = 1'b1;
    end else begin
      if (p.state != bhs_pkg::ST_CLAMP && p.state != bhs_pkg::ST_DOWN) begin
        p = run_clamp(p, present_i);
      end
      if (p.state != bhs_pkg::ST_CLAMP && p.state != bhs_pkg::ST_DOWN) begin
        p.success = 1'b0;
      end else begin
        p = add_pulse(p, bhs_pkg::P_LIFT_UP);
        p.state   = bhs_pkg::ST_UP;
        p.success = 1'b1;
      end
    end
    return p;
  endfunction

  function automatic bhs_pkg::plan_t run_lower(bhs_pkg::plan_t p);
    if (p.state == bhs_pkg::ST_DOWN) begin
      p.success = 1'b1;
    end else if (p.state != bhs_pkg::ST_UP) begin
      p.success = 1'b0;
    end else begin
      p = add_pulse(p, bhs_pkg::P_LIFT_DOWN);
      p.state   = bhs_pkg::ST_DOWN;
      p.success = 1'b1;
    end
    return p;
  endfunction

  function automatic bhs_pkg::plan_t run_release(bhs_pkg::plan_t p);
    if (p.state == bhs_pkg::ST_RELEASE) begin
      p.success = 1'b1;
    end else begin
      if (p.state != bhs_pkg::ST_DOWN) begin
        p = run_lower(p);
      end
      if (p.state != bhs_pkg::ST_DOWN && p.state != bhs_pkg::ST_CLAMP) begin
        p.success = 1'b0;
      end else begin
        p = add_pulse(p, bhs_pkg::P_UNCLAMP);
        p.state   = bhs_pkg::ST_RELEASE;
        p.success = 1'b1;
      end
    end
    return p;
  endfunction

  function automatic bhs_pkg::plan_t run_send_out(bhs_pkg::plan_t p);
    if (p.state == bhs_pkg::ST_OUT) begin
      p.success = 1'b1;
    end else begin
      if (p.state != bhs_pkg::ST_RELEASE) begin
        p = run_release(p);
      end
      if (p.state != bhs_pkg::ST_RELEASE && p.state != bhs_pkg::ST_ACCEPT) begin
        p.success = 1'b0;
      end else begin
        p = add_pulse(p, bhs_pkg::P_GATE_DOWN);
        p = add_pulse(p, bhs_pkg::P_EXIT_RUN);
        p.state   = bhs_pkg::ST_OUT;
        p.success = 1'b1;
      end
    end
    return p;
  endfunction

  // The configured entry sensor is active low.
  assign present = entry_from_left_i ? !cmd_i.data.entry_sensors_n[0]
                                     : !cmd_i.data.entry_sensors_n[1];

  // Classify the command into a plan of pulses and a final status.
  always_comb begin
    plan       = '0;
    plan.state = state_q;
    unique case (cmd_i.data.operation)
      bhs_pkg::OP_CLEAR: begin
        plan.state = bhs_pkg::ST_NONE;
        plan = add_pulse(plan, bhs_pkg::P_LIFT_DOWN);
        plan = add_pulse(plan, bhs_pkg::P_UNCLAMP);
        plan = add_pulse(plan, bhs_pkg::P_GATE_DOWN);
        plan.success = 1'b1;
      end
      bhs_pkg::OP_ACCEPT:   plan = run_accept(plan, present);
      bhs_pkg::OP_CLAMP:    plan = run_clamp(plan, present);
      bhs_pkg::OP_RAISE:    plan = run_raise(plan, present);
      bhs_pkg::OP_LOWER:    plan = run_lower(plan);
      bhs_pkg::OP_RELEASE:  plan = run_release(plan);
      bhs_pkg::OP_SEND_OUT: plan = run_send_out(plan);
      default:              plan.success = 1'b0;
    endcase
  end

  // Handshake: a command is taken whenever the queue has room.
  assign cmd_i.ready  = push_ready_i;
  assign take         = cmd_i.valid && push_ready_i;
  assign push_valid_o = cmd_i.valid;
  assign push_plan_o  = plan;

  // The tracked board state moves on when a command is taken.
  always_comb begin
    state_d = state_q;
    if (take) begin
      state_d = plan.state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bhs_pkg::ST_NONE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/bhs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Board handling sequencer plan queue
// Short first-in first-out queue of plans between the front and back end.
// ----------------------------------------------------------------------------
module bhs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  bhs_pkg::plan_t push_plan_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output bhs_pkg::plan_t pop_plan_o,
  input  logic           pop_i
);

  localparam int unsigned PtrW = (bhs_pkg::QueueDepth > 1) ? $clog2(bhs_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(bhs_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(bhs_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(bhs_pkg::QueueDepth);

  bhs_pkg::plan_t  entry_q [bhs_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_plan_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_plan_i;
    end
  end

endmodule

### rtl/bhs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Board handling sequencer back end
// Plays out the plan at the queue head: one pulse word per cycle while
// the result is taken, then the status word, via a registered output stage.
// ----------------------------------------------------------------------------
module bhs_back #(
  parameter logic [bhs_pkg::MsW-1:0] PULSE_MS = bhs_pkg::PulseMsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  bhs_pkg::plan_t             head_plan_i,
  output logic                       pop_o,
  input  logic [bhs_pkg::MsW-1:0]    entry_run_ms_i,
  input  logic [bhs_pkg::MsW-1:0]    exit_run_ms_i,
  bhs_stream_if.source               res_o
);

  logic [bhs_pkg::PulseCntW-1:0] idx_q, idx_d;
  logic                          valid_q, valid_d;
  bhs_pkg::res_t                 res_q, res_d;
  logic                          advance;
  logic                          in_pulses;
  bhs_pkg::pulse_e               cur_pulse;

  // The output stage moves when it is empty or being taken.
  assign advance   = !valid_q || res_o.ready;
  assign in_pulses = (idx_q < head_plan_i.pulse_cnt);
  assign cur_pulse = head_plan_i.pulse[idx_q[bhs_pkg::PulseIdxW-1:0]];
  assign pop_o     = advance && head_valid_i && !in_pulses;

  // Next word and step counter.
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    res_d   = res_q;
    if (advance) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        res_d = '0;
        if (in_pulses) begin
          idx_d = idx_q + bhs_pkg::PulseCntW'(1);
          unique case (cur_pulse)
            bhs_pkg::P_GATE_UP: begin
              res_d.actuator = bhs_pkg::ACT_GATE_UP;
              res_d.pulse_ms = PULSE_MS;
            end
            bhs_pkg::P_GATE_DOWN: begin
              res_d.actuator = bhs_pkg::ACT_GATE_DOWN;
              res_d.pulse_ms = PULSE_MS;
            end
            bhs_pkg::P_ENTRY_RUN: begin
              res_d.actuator = bhs_pkg::ACT_CONVEYOR;
              res_d.pulse_ms = entry_run_ms_i;
            end
            bhs_pkg::P_EXIT_RUN: begin
              res_d.actuator = bhs_pkg::ACT_CONVEYOR;
              res_d.pulse_ms = exit_run_ms_i;
            end
            bhs_pkg::P_CLAMP: begin
              res_d.actuator = bhs_pkg::ACT_CLAMP;
              res_d.pulse_ms = PULSE_MS;
            end
            bhs_pkg::P_UNCLAMP: begin
              res_d.actuator = bhs_pkg::ACT_UNCLAMP;
              res_d.pulse_ms = PULSE_MS;
            end
            bhs_pkg::P_LIFT_UP: begin
              res_d.actuator = bhs_pkg::ACT_LIFT_UP;
              res_d.pulse_ms = PULSE_MS;
            end
            bhs_pkg::P_LIFT_DOWN: begin
              res_d.actuator = bhs_pkg::ACT_LIFT_DOWN;
              res_d.pulse_ms = PULSE_MS;
            end
            default: begin
              res_d.actuator = bhs_pkg::ACT_NONE;
            end
          endcase
        end else begin
          // Status word closes the command.
          idx_d             = '0;
          res_d.actuator    = bhs_pkg::ACT_NONE;
          res_d.success     = head_plan_i.success;
          res_d.board_state = head_plan_i.state;
          res_d.last        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o.valid = valid_q;
  assign res_o.data  = res_q;

endmodule

### rtl/board_handling_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Board handling sequencer
// Command sequencer for a board on an inspection conveyor.
// ----------------------------------------------------------------------------
// Each command word is classified in the cycle it is taken: the front end
// resolves the whole prerequisite cascade against the tracked board state
// and stores a plan in a two-entry queue, so commands are taken one per
// cycle while the queue has room. The back end then issues the plan one
// word per cycle while the result is taken, through a registered output:
// one word per actuator pulse plus a status word, so one to five words a
// command; that output rate sets the sustained pace. Configuration words
// are taken at any time but must only be written while the block is idle.
// ----------------------------------------------------------------------------
module board_handling_sequencer #(
  parameter logic [bhs_pkg::MsW-1:0] PULSE_MS = bhs_pkg::PulseMsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bhs_stream_if.sink   cmd_i,
  bhs_stream_if.sink   cfg_i,
  bhs_stream_if.source res_o
);

  logic                       entry_from_left_q;
  logic [bhs_pkg::MsW-1:0]    entry_run_ms_q;
  logic [bhs_pkg::MsW-1:0]    exit_run_ms_q;
  logic                       cfg_we;
  logic                       push_valid;
  logic                       push_ready;
  bhs_pkg::plan_t             push_plan;
  logic                       head_valid;
  bhs_pkg::plan_t             head_plan;
  logic                       pop;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_from_left_q <= bhs_pkg::EntryFromLeftReset;
      entry_run_ms_q    <= bhs_pkg::EntryRunMsReset;
      exit_run_ms_q     <= bhs_pkg::ExitRunMsReset;
    end else if (cfg_we) begin
      unique case (cfg_i.data.index)
        bhs_pkg::REG_ENTRY_FROM_LEFT: entry_from_left_q <= cfg_i.data.data[0];
        bhs_pkg::REG_ENTRY_RUN_MS:    entry_run_ms_q    <= cfg_i.data.data;
        bhs_pkg::REG_EXIT_RUN_MS:     exit_run_ms_q     <= cfg_i.data.data;
        default: ;
      endcase
    end
  end

  // Command classification.
  bhs_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd_i),
    .entry_from_left_i (entry_from_left_q),
    .push_valid_o      (push_valid),
    .push_plan_o       (push_plan),
    .push_ready_i      (push_ready)
  );

  // Plan queue.
  bhs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_plan_i  (push_plan),
    .push_ready_o (push_ready),
    .pop_valid_o  (head_valid),
    .pop_plan_o   (head_plan),
    .pop_i        (pop)
  );

  // Pulse and status output.
  bhs_back #(
    .PULSE_MS (PULSE_MS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_plan_i    (head_plan),
    .pop_o          (pop),
    .entry_run_ms_i (entry_run_ms_q),
    .exit_run_ms_i  (exit_run_ms_q),
    .res_o          (res_o)
  );

endmodule
